// ===== hdl/crm_pkg.sv =====
`default_nettype none

package crm_pkg;

  localparam int MAX_CONDITIONS = 32;
  localparam int NUM_FEATURES   = 256;

  localparam int COND_AW = (MAX_CONDITIONS > 1) ? $clog2(MAX_CONDITIONS) : 1;
  localparam int FEAT_AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CNT_W   = $clog2(MAX_CONDITIONS + 1);

  localparam int KIND_W  = 3;
  localparam int FIDX_W  = 8;
  localparam int SLOT_W  = 5;
  localparam int VALUE_W = 32;
  localparam int CCNT_W  = 6;
  localparam int COND_W  = KIND_W + FIDX_W + VALUE_W;

  localparam logic [1:0] CMD_COND = 2'd0;
  localparam logic [1:0] CMD_FEAT = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NUM_LE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NUM_GT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ORD_LE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ORD_GT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOM_EQ = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOM_NE = 3'd5;

  localparam logic REG_COUNT  = 1'b0;
  localparam logic REG_SPARSE = 1'b1;

  typedef struct packed {
    logic               cond_we;
    logic               feat_we;
    logic               walk_start;
    logic [COND_AW-1:0] cond_raddr;
    logic               s1_valid;
    logic               s2_valid;
    logic               clear_present;
    logic               out_load;
  } crm_cmd_t;

  typedef struct packed {
    logic out_free;
  } crm_status_t;

  // Integer part of a Q16.16 value, rounded toward zero.
  function automatic logic signed [15:0] trunc_int(input logic signed [VALUE_W-1:0] q);
    logic adj;
    adj = q[VALUE_W-1] && (q[15:0] != 16'd0);
    return signed'(q[VALUE_W-1:16] + {15'd0, adj});
  endfunction

  function automatic logic cond_holds(input logic [KIND_W-1:0] k,
                                      input logic signed [VALUE_W-1:0] f,
                                      input logic signed [VALUE_W-1:0] t);
    logic signed [15:0] fi;
    logic signed [15:0] ti;
    logic               res;
    fi = trunc_int(f);
    ti = trunc_int(t);
    case (k)
      KIND_NUM_LE: res = (f <= t);
      KIND_NUM_GT: res = (f > t);
      KIND_ORD_LE: res = (fi <= ti);
      KIND_ORD_GT: res = (fi > ti);
      KIND_NOM_EQ: res = (fi == ti);
      KIND_NOM_NE: res = (fi != ti);
      default:     res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/crm_ram.sv =====
`default_nettype none

module crm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/crm_datapath.sv =====
`default_nettype none

module crm_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire crm_pkg::crm_cmd_t                      cmd_i,
  output crm_pkg::crm_status_t                        status_o,
  input  wire logic [crm_pkg::SLOT_W-1:0]             slot_i,
  input  wire logic [crm_pkg::KIND_W-1:0]             kind_i,
  input  wire logic [crm_pkg::FIDX_W-1:0]             feature_index_i,
  input  wire logic signed [crm_pkg::VALUE_W-1:0]     value_i,
  input  wire logic signed [crm_pkg::VALUE_W-1:0]     sparse_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic                                        covered_o
);

  logic [crm_pkg::COND_W-1:0]          cond_wdata;
  logic [crm_pkg::COND_W-1:0]          cond_rdata;
  logic                                cond_we;
  logic                                feat_we;
  logic [crm_pkg::KIND_W-1:0]          rd_kind;
  logic [crm_pkg::FIDX_W-1:0]          rd_feat;
  logic signed [crm_pkg::VALUE_W-1:0]  rd_thr;
  logic signed [crm_pkg::VALUE_W-1:0]  feat_rdata;
  logic signed [crm_pkg::VALUE_W-1:0]  fv;
  logic                                rd_in_range;

  logic [crm_pkg::NUM_FEATURES-1:0]    present_q;
  logic [crm_pkg::KIND_W-1:0]          kind2_q;
  logic signed [crm_pkg::VALUE_W-1:0]  thr2_q;
  logic                                pres2_q;
  logic                                acc_q;
  logic                                out_valid_q;
  logic                                covered_q;

  assign cond_wdata = {kind_i, feature_index_i, value_i};
  assign cond_we    = cmd_i.cond_we && (32'(slot_i) < crm_pkg::MAX_CONDITIONS);
  assign feat_we    = cmd_i.feat_we && (32'(feature_index_i) < crm_pkg::NUM_FEATURES);

  crm_ram #(
    .WIDTH (crm_pkg::COND_W),
    .DEPTH (crm_pkg::MAX_CONDITIONS)
  ) u_cond_ram (
    .clk_i   (clk_i),
    .we_i    (cond_we),
    .waddr_i (slot_i[crm_pkg::COND_AW-1:0]),
    .wdata_i (cond_wdata),
    .raddr_i (cmd_i.cond_raddr),
    .rdata_o (cond_rdata)
  );

  assign rd_kind     = cond_rdata[crm_pkg::COND_W-1 -: crm_pkg::KIND_W];
  assign rd_feat     = cond_rdata[crm_pkg::VALUE_W +: crm_pkg::FIDX_W];
  assign rd_thr      = signed'(cond_rdata[crm_pkg::VALUE_W-1:0]);
  assign rd_in_range = (32'(rd_feat) < crm_pkg::NUM_FEATURES);

  crm_ram #(
    .WIDTH (crm_pkg::VALUE_W),
    .DEPTH (crm_pkg::NUM_FEATURES)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (feature_index_i[crm_pkg::FEAT_AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (rd_feat[crm_pkg::FEAT_AW-1:0]),
    .rdata_o (feat_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.clear_present) begin
      present_q <= '0;
    end else if (feat_we) begin
      present_q[feature_index_i[crm_pkg::FEAT_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s1_valid) begin
      kind2_q <= rd_kind;
      thr2_q  <= rd_thr;
      pres2_q <= rd_in_range && present_q[rd_feat[crm_pkg::FEAT_AW-1:0]];
    end
  end

  assign fv = pres2_q ? feat_rdata : sparse_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b1;
    end else if (cmd_i.walk_start) begin
      acc_q <= 1'b1;
    end else if (cmd_i.s2_valid) begin
      acc_q <= acc_q & crm_pkg::cond_holds(kind2_q, fv, thr2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      covered_q <= acc_q;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign covered_o         = covered_q;

endmodule

`default_nettype wire

// ===== hdl/crm_ctrl.sv =====
`default_nettype none

module crm_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [crm_pkg::CCNT_W-1:0]    count_i,
  input  wire crm_pkg::crm_status_t          status_i,
  output crm_pkg::crm_cmd_t                  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                  state_q;
  logic [1:0]                  state_d;
  logic [crm_pkg::CNT_W-1:0]   issue_q;
  logic [crm_pkg::CNT_W-1:0]   issue_d;
  logic                        v1_q;
  logic                        v2_q;
  logic [crm_pkg::CNT_W-1:0]   num;
  logic                        accept;
  logic                        start;
  logic                        issue;
  logic                        walk_done;

  assign num = (32'(count_i) > crm_pkg::MAX_CONDITIONS) ?
               crm_pkg::CNT_W'(crm_pkg::MAX_CONDITIONS) : crm_pkg::CNT_W'(count_i);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (cmd_i == crm_pkg::CMD_EVAL);
  assign issue      = (state_q == ST_WALK) && (issue_q < num);
  assign walk_done  = (state_q == ST_WALK) && (issue_q == num) && !v1_q && !v2_q;

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WALK;
          issue_d = '0;
        end
      end
      ST_WALK: begin
        if (issue) begin
          issue_d = issue_q + 1'b1;
        end
        if (walk_done) begin
          state_d = status_i.out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      issue_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
    end
  end

  always_comb begin
    cmd_o               = '0;
    cmd_o.cond_we       = accept && (cmd_i == crm_pkg::CMD_COND);
    cmd_o.feat_we       = accept && (cmd_i == crm_pkg::CMD_FEAT);
    cmd_o.walk_start    = start;
    cmd_o.cond_raddr    = issue_q[crm_pkg::COND_AW-1:0];
    cmd_o.s1_valid      = v1_q;
    cmd_o.s2_valid      = v2_q;
    cmd_o.clear_present = walk_done;
    cmd_o.out_load      = (walk_done || (state_q == ST_HOLD)) && status_i.out_free;
  end

  a_issue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (issue_q <= num))
    else $error("Condition walk ran past the table length.");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("Result loaded while the output register still holds a transfer.");

  a_start_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_WALK) && (issue_q == '0))
    else $error("Evaluate transfer did not start a walk.");

  a_clear_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_present |-> !v1_q && !v2_q && (issue_q == num))
    else $error("Present marks cleared before the walk drained.");

endmodule

`default_nettype wire

// ===== hdl/conjunctive_rule_matcher.sv =====
// Feature, condition and ignored transfers are taken back to back whenever the block is idle.
// An evaluate transfer walks the condition table through two registered RAM reads
// over n = min(condition_count, 32) entries, one entry per cycle.
// The input stalls until the walk's result is loaded into the output register, where it waits.
// Reset clears APB, control, accumulator and out-valid registers and present marks, not the RAMs.
`default_nettype none

module conjunctive_rule_matcher (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic [crm_pkg::SLOT_W-1:0]          slot_i,
  input  wire logic [crm_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [crm_pkg::FIDX_W-1:0]          feature_index_i,
  input  wire logic signed [crm_pkg::VALUE_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     covered_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [crm_pkg::CCNT_W-1:0]          count_q;
  logic signed [crm_pkg::VALUE_W-1:0]  sparse_q;
  logic                                reg_we;
  crm_pkg::crm_cmd_t                   cmd;
  crm_pkg::crm_status_t                status;

  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sparse_q <= '0;
    end else if (reg_we) begin
      case (paddr[2])
        crm_pkg::REG_COUNT:  count_q  <= pwdata[crm_pkg::CCNT_W-1:0];
        crm_pkg::REG_SPARSE: sparse_q <= signed'(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      crm_pkg::REG_COUNT:  prdata = 32'(count_q);
      crm_pkg::REG_SPARSE: prdata = sparse_q;
      default:             prdata = '0;
    endcase
  end

  crm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .count_i    (count_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .slot_i          (slot_i),
    .kind_i          (kind_i),
    .feature_index_i (feature_index_i),
    .value_i         (value_i),
    .sparse_i        (sparse_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .covered_o       (covered_o)
  );

endmodule

`default_nettype wire
